>>> src/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first scheduler.
// Used by every module under src; depends on nothing else.
package srtf_pkg;

  localparam int unsigned PC_W = 5;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  entry_index;
    logic [15:0] arr_time;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic        busy_res;
    logic [3:0]  chosen_entry;
    logic [31:0] slot_start;
    logic        entry_finished;
    logic        all_done;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } seq_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic cmp_v;
    logic clr;
    logic upd;
  } seq_ctl_t;

endpackage

>>> src/srtf_table.sv
// Entry table: arrival times and remaining times, one read port with registered data.
// Remaining times carry per-entry valid bits so an unwritten entry reads as zero.
// Depends on srtf_pkg.
module srtf_table
  import srtf_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             arr_we,
  input  logic             rem_we,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [15:0]      wr_arr,
  input  logic [15:0]      wr_rem,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [15:0]      rd_arr,
  output logic [15:0]      rd_rem
);

  logic [15:0]            arr_mem [MAX_ENTRIES];
  logic [15:0]            rem_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_r;
  logic [15:0]            arr_q_r;
  logic [15:0]            rem_q_r;
  logic                   vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (rem_we) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[wr_idx] <= wr_arr;
    end
    if (rem_we) begin
      rem_mem[wr_idx] <= wr_rem;
    end
    if (rd_en) begin
      arr_q_r <= arr_mem[rd_idx];
      rem_q_r <= rem_mem[rd_idx];
      vld_q_r <= vld_r[rd_idx];
    end
  end

  assign rd_arr = arr_q_r;
  assign rd_rem = vld_q_r ? rem_q_r : 16'd0;

endmodule

>>> src/srtf_cmp.sv
// Shared compare unit: takes one table entry per cycle and keeps the best candidate
// and the count of unfinished entries seen. Depends on srtf_pkg.
module srtf_cmp
  import srtf_pkg::*;
#(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk,
  input  seq_ctl_t         ctl,
  input  logic [IDX_W-1:0] cmp_idx,
  input  logic [15:0]      cmp_arr,
  input  logic [15:0]      cmp_rem,
  input  logic [31:0]      cur_time,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output logic [15:0]      best_rem,
  output logic [CNT_W-1:0] live_cnt
);

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]      best_rem_r, best_rem_nxt;
  logic [15:0]      best_arr_r, best_arr_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic             eligible;
  logic             better;

  always_comb begin
    eligible = (cmp_rem != 16'd0) && ({16'd0, cmp_arr} <= cur_time);
    better   = !found_r || (cmp_rem < best_rem_r) ||
               ((cmp_rem == best_rem_r) && (cmp_arr < best_arr_r));
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_rem_nxt = best_rem_r;
    best_arr_nxt = best_arr_r;
    live_nxt     = live_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
      live_nxt  = '0;
    end else if (ctl.cmp_v) begin
      if (cmp_rem != 16'd0) begin
        live_nxt = live_r + CNT_W'(1);
      end
      // Strict comparison keeps the lower index on a full tie.
      if (eligible && better) begin
        found_nxt    = 1'b1;
        best_idx_nxt = cmp_idx;
        best_rem_nxt = cmp_rem;
        best_arr_nxt = cmp_arr;
      end
    end
  end

  // The sequencer always clears before a scan, so no reset is needed here.
  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_rem_r <= best_rem_nxt;
    best_arr_r <= best_arr_nxt;
    live_r     <= live_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_rem = best_rem_r;
  assign live_cnt = live_r;

endmodule

>>> src/srtf_seq.sv
// Sequencer: accepts an item, walks the entries in use through the compare unit,
// then issues one update cycle. Depends on srtf_pkg.
module srtf_seq
  import srtf_pkg::*;
#(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] n_used,
  output seq_ctl_t         ctl,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] cmp_idx
);

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             issue;

  assign issue = (state_r == ST_SCAN) && (addr_r < n_used);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // The last read returns during the final scan cycle.
        if (!issue) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.busy  = (state_r != ST_IDLE);
    ctl.rd_en = issue;
    ctl.cmp_v = rd_v_r;
    ctl.clr   = (state_r == ST_IDLE) && start;
    ctl.upd   = (state_r == ST_UPDATE);
    addr_nxt  = (state_r == ST_SCAN) ? (addr_r + CNT_W'(issue)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      rd_v_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r[IDX_W-1:0];
  end

  assign rd_addr = addr_r[IDX_W-1:0];
  assign cmp_idx = rd_idx_r;

endmodule

>>> src/srtf_scheduler_unit.sv
// Shortest-remaining-time-first scheduler, top level.
// Each item goes from acceptance to its result strobe through a scan of the n entries in use:
// the compare unit reads one table entry per cycle, then the update state writes the slot report.
// A new item may be accepted in the cycle its predecessor's result is shown; the receiver
// cannot stall. Synchronous active-low reset clears time, count, remaining times and control.
// Depends on srtf_pkg, srtf_seq, srtf_table and srtf_cmp.
module srtf_scheduler_unit
  import srtf_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_data,
  output logic            out_valid,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PC_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  seq_ctl_t         ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] cmp_idx;
  logic [15:0]      rd_arr;
  logic [15:0]      rd_rem;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [15:0]      best_rem;
  logic [CNT_W-1:0] live_cnt;

  logic [PC_W-1:0]  pc_r;
  logic [31:0]      time_r;
  logic             act_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             accept;
  logic [31:0]      pc32;
  logic [31:0]      n32;
  logic [CNT_W-1:0] n_used;
  logic [31:0]      eidx32;
  logic             load_ok;
  logic             run;
  logic [15:0]      rem_dec;
  logic             fin;
  logic [31:0]      best32;
  logic             arr_we;
  logic             rem_we;
  logic [IDX_W-1:0] wr_idx;
  logic [15:0]      wr_rem;

  assign busy      = ctl.busy;
  assign accept    = start && !ctl.busy;
  // The entry count steers the scan, so it only changes between items.
  assign cfg_ready = !ctl.busy;

  always_comb begin
    pc32    = 32'(pc_r);
    n32     = (pc32 > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : pc32;
    n_used  = n32[CNT_W-1:0];
    eidx32  = 32'(in_data.entry_index);
    load_ok = accept && (in_data.action == ACT_LOAD) && (eidx32 < MAX_ENTRIES);
    run     = ctl.upd && (act_r == ACT_TICK) && found;
    rem_dec = best_rem - 16'd1;
    fin     = run && (rem_dec == 16'd0);
    best32  = 32'(best_idx);
    // Loads write at acceptance; the tick's decrement writes in the update cycle.
    arr_we  = load_ok;
    rem_we  = load_ok || run;
    wr_idx  = run ? best_idx : eidx32[IDX_W-1:0];
    wr_rem  = run ? rem_dec : in_data.burst_length;
  end

  srtf_seq #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .n_used  (n_used),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .cmp_idx (cmp_idx)
  );

  srtf_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .arr_we (arr_we),
    .rem_we (rem_we),
    .wr_idx (wr_idx),
    .wr_arr (in_data.arr_time),
    .wr_rem (wr_rem),
    .rd_en  (ctl.rd_en),
    .rd_idx (rd_addr),
    .rd_arr (rd_arr),
    .rd_rem (rd_rem)
  );

  srtf_cmp #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_cmp (
    .clk      (clk),
    .ctl      (ctl),
    .cmp_idx  (cmp_idx),
    .cmp_arr  (rd_arr),
    .cmp_rem  (rd_rem),
    .cur_time (time_r),
    .found    (found),
    .best_idx (best_idx),
    .best_rem (best_rem),
    .live_cnt (live_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pc_r <= cfg_data;
      end
      if (ctl.upd && (act_r == ACT_TICK)) begin
        time_r <= time_r + 32'd1;
      end
      out_valid_r <= ctl.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_data.action;
    end
    if (ctl.upd) begin
      out_data_r.busy_res       <= run;
      out_data_r.chosen_entry   <= run ? best32[3:0] : 4'd0;
      out_data_r.slot_start     <= time_r;
      out_data_r.entry_finished <= fin;
      // A finishing entry was counted as unfinished during the scan.
      out_data_r.all_done       <= (live_cnt == CNT_W'(fin));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the sequencer is busy");

  a_idle_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.busy_res) |->
      (out_data.chosen_entry == 4'd0) && !out_data.entry_finished)
    else $error("idle result carries an entry or a finish flag");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");
`endif

endmodule

>>> test/srtf_scheduler_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for srtf_scheduler_unit: random load and tick items, every slot
// report checked against an in-bench scheduler model. Depends on srtf_pkg and the RTL.
module srtf_scheduler_unit_test;
  import srtf_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_item_t        in_data;
  logic            out_valid;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [PC_W-1:0] cfg_data;

  srtf_scheduler_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Scheduler state as the bench sees it.
  logic [15:0]     arr_tbl [TABLE_DEPTH];
  logic [15:0]     rem_tbl [TABLE_DEPTH];
  logic [31:0]     now_time;
  logic [PC_W-1:0] proc_count;

  in_item_t  request_q[$];
  out_item_t slot_q[$];
  out_item_t want;
  logic      accepted_q;
  int        gap_left;
  int        gap_pct;
  int        fail_count;
  int        queued_items;
  int        gen_time;

  function automatic out_item_t run_slot(in_item_t req);
    out_item_t   rpt;
    int unsigned live;
    int          best;
    live = (proc_count > TABLE_DEPTH) ? TABLE_DEPTH : proc_count;
    rpt = '0;
    rpt.slot_start = now_time;
    best = -1;
    if (req.action == ACT_LOAD) begin
      arr_tbl[req.entry_index] = req.arr_time;
      rem_tbl[req.entry_index] = req.burst_length;
    end else begin
      for (int i = 0; i < live; i++) begin
        if (rem_tbl[i] != 0 && arr_tbl[i] <= now_time) begin
          if (best < 0 || rem_tbl[i] < rem_tbl[best] ||
              (rem_tbl[i] == rem_tbl[best] && arr_tbl[i] < arr_tbl[best])) begin
            best = i;
          end
        end
      end
      if (best >= 0) begin
        rem_tbl[best] = rem_tbl[best] - 16'd1;
        rpt.busy_res = 1'b1;
        rpt.chosen_entry = best[3:0];
        rpt.entry_finished = (rem_tbl[best] == 0);
      end
      now_time = now_time + 32'd1;
    end
    rpt.all_done = 1'b1;
    for (int i = 0; i < live; i++) begin
      if (rem_tbl[i] != 0) begin
        rpt.all_done = 1'b0;
      end
    end
    return rpt;
  endfunction

  function automatic void push_load(int idx, logic [15:0] arrival, logic [15:0] burst);
    in_item_t req;
    req.action = ACT_LOAD;
    req.entry_index = idx[3:0];
    req.arr_time = arrival;
    req.burst_length = burst;
    request_q.insert(request_q.size(), req);
    queued_items++;
  endfunction

  // Tick items carry random filler in the unused fields.
  function automatic void push_tick();
    in_item_t req;
    req.action = ACT_TICK;
    req.entry_index = 4'($urandom);
    req.arr_time = 16'($urandom);
    req.burst_length = 16'($urandom);
    request_q.insert(request_q.size(), req);
    queued_items++;
    gen_time++;
  endfunction

  function automatic logic [15:0] pick_burst();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return 16'd0;
    end else if (roll == 1) begin
      return 16'($urandom_range(0, 65535));
    end else if (roll == 2) begin
      return 16'($urandom_range(9, 40));
    end
    return 16'($urandom_range(1, 8));
  endfunction

  function automatic logic [15:0] pick_arrival();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return 16'($urandom_range(0, 65535));
    end else if (roll < 4) begin
      return 16'($urandom_range(0, gen_time));
    end
    return 16'(gen_time + $urandom_range(0, 8));
  endfunction

  task automatic write_count(input logic [PC_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender back until every queued item has come back as a slot report.
  // The second wait samples only from a later falling edge, so the last item's start is seen.
  task automatic drain();
    do @(negedge clk); while (request_q.size() != 0);
    do @(negedge clk); while (start || busy || slot_q.size() != 0);
    repeat (3) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || accepted_q) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (request_q.size() != 0) begin
        if ($urandom_range(0, 99) < gap_pct) begin
          gap_left <= $urandom_range(0, 24);
          start <= 1'b0;
        end else begin
          in_data <= request_q.pop_front();
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      accepted_q <= 1'b0;
    end else begin
      // The report of the previous item may share an edge with the next acceptance.
      if (out_valid) begin
        if (slot_q.size() == 0) begin
          $error("slot report with no item outstanding");
          fail_count++;
        end else begin
          want = slot_q.pop_front();
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
            fail_count++;
          end
          if (out_data.chosen_entry !== want.chosen_entry) begin
            $error("chosen_entry: expected %0d, got %0d", want.chosen_entry,
                   out_data.chosen_entry);
            fail_count++;
          end
          if (out_data.slot_start !== want.slot_start) begin
            $error("slot_start: expected %0d, got %0d", want.slot_start, out_data.slot_start);
            fail_count++;
          end
          if (out_data.entry_finished !== want.entry_finished) begin
            $error("entry_finished: expected %0d, got %0d", want.entry_finished,
                   out_data.entry_finished);
            fail_count++;
          end
          if (out_data.all_done !== want.all_done) begin
            $error("all_done: expected %0d, got %0d", want.all_done, out_data.all_done);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        proc_count = cfg_data;
      end
      if (start && !busy) begin
        slot_q.insert(slot_q.size(), run_slot(in_data));
      end
      accepted_q <= start && !busy;
    end
  end

  initial begin
    int phase;
    int cnt;
    int live;
    int work;
    int ticks;
    int target;
    logic [15:0] burst;

    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    gap_left = 0;
    gap_pct = 30;
    fail_count = 0;
    queued_items = 0;
    gen_time = 0;
    now_time = '0;
    proc_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      arr_tbl[i] = '0;
      rem_tbl[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: idle slots with everything reported done.
    write_count('0);
    push_tick();
    push_tick();
    drain();

    // Fill the whole table so no entry is ever read before it is written.
    push_load(0, 16'd0, 16'd0);
    push_load(1, 16'd1, 16'd2);
    push_load(2, 16'd0, 16'd2);
    push_load(3, 16'd0, 16'd2);
    for (int i = 4; i < 15; i++) begin
      push_load(i, 16'(40000 + i), (i % 2) ? 16'h5555 : 16'hAAAA);
    end
    push_load(15, 16'hFFFF, 16'hFFFF);
    drain();

    // Ties on remaining time: earlier arrival first, then the lower index.
    write_count(PC_W'(TABLE_DEPTH));
    repeat (5) push_tick();
    drain();

    // A count above the table size is clamped to the table size.
    write_count(5'd31);
    repeat (2) push_tick();
    drain();

    phase = 0;
    while (queued_items < 740) begin
      case (phase)
        0: cnt = TABLE_DEPTH;
        1: cnt = 1;
        default: cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(2, TABLE_DEPTH);
      endcase
      live = cnt;
      gap_pct = (phase == 2) ? 0 : 30;
      write_count(cnt[PC_W-1:0]);
      target = queued_items + 130;
      if (target > 750) begin
        target = 750;
      end
      while (queued_items < target) begin
        // A job set: reload most entries in use, a few beyond the count, then run it.
        work = 0;
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if ((e < live) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0)) begin
            burst = pick_burst();
            push_load(e, pick_arrival(), burst);
            if (e < live) begin
              work += burst;
            end
          end
        end
        ticks = (work + 12 < 60) ? work + 12 : 60;
        for (int t = 0; t < ticks; t++) begin
          // Late arrivals with short bursts exercise preemption.
          if ($urandom_range(0, 9) == 0) begin
            push_load($urandom_range(0, TABLE_DEPTH - 1), pick_arrival(),
                      (pick_burst() & 16'h000F));
          end
          push_tick();
        end
      end
      drain();
      phase++;
    end

    repeat (25) @(posedge clk);
    if (slot_q.size() != 0) begin
      $error("%0d slot reports never arrived", slot_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
